### design/assert_macros.svh
// Assertion helpers. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, written by the caller with |->.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/fnsw_pkg.sv
package fnsw_pkg;

  localparam int WORD_W   = 32;
  localparam int SECTOR_W = 32;
  localparam int BYTE_W   = 35;  // byte offset of an entry, up to 4 * 2^32

  // table format codes
  localparam logic [1:0] FAT_TYPE_12  = 2'd0;
  localparam logic [1:0] FAT_TYPE_16  = 2'd1;
  localparam logic [1:0] FAT_TYPE_32  = 2'd2;
  localparam logic [1:0] FAT_TYPE_RSV = 2'd3;  // decoded as FAT32

  // configuration register indexes
  localparam logic [1:0] CFG_FAT_TYPE      = 2'd0;
  localparam logic [1:0] CFG_DATA_START    = 2'd1;
  localparam logic [1:0] CFG_CLUSTER_SHIFT = 2'd2;

  // request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // end / reserved thresholds
  localparam logic [31:0] FAT12_LIMIT = 32'h0000_0ff0;
  localparam logic [31:0] FAT16_LIMIT = 32'h0000_fff0;
  localparam logic [31:0] FAT32_LIMIT = 32'h0fff_fff0;
  localparam logic [31:0] FAT32_MASK  = 32'h0fff_ffff;
  localparam logic [15:0] FAT12_MASK  = 16'h0fff;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CLUS = 7'b0000010,
    S_BYTE = 7'b0000100,
    S_READ = 7'b0001000,
    S_DATA = 7'b0010000,
    S_MAP  = 7'b0100000,
    S_DONE = 7'b1000000
  } walk_state_t;

endpackage

### design/fat_next_sector_walker.sv
// Load transaction: written to the table at the accepting edge; loads go back to back.
// Query below the data area or inside a cluster: the walk goes from S_CLUS to S_DONE.
// Query at a cluster's last sector: S_CLUS, S_BYTE, S_READ, S_DATA, S_MAP, S_DONE, or S_READ
// to S_DONE when the entry lies beyond the table. One query is walked at a time; the next
// transaction is taken the cycle after the result moves to the output register.
// Synchronous active-low reset clears sequencer, output valid and config; table undefined.
module fat_next_sector_walker #(
  parameter int FAT_WORDS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_wdata,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [11:0]                   in_word_index,
  input  logic [fnsw_pkg::WORD_W-1:0]   in_word_data,
  input  logic [fnsw_pkg::SECTOR_W-1:0] in_sector,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fnsw_pkg::SECTOR_W-1:0] out_succ_sector,
  output logic                          out_end_of_chain,
  output logic                          out_out_of_range
);
  import fnsw_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = (FAT_WORDS > 1) ? $clog2(FAT_WORDS) : 1;
  // index compare width: wide enough for the load index and for FAT_WORDS itself
  localparam int XW = ((AW > 12) ? AW : 12) + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(FAT_WORDS);
  // an entry is out of the store when its second byte is at or past the end,
  // i.e. when its first byte offset is at or past 4*FAT_WORDS - 1
  localparam logic [BYTE_W-1:0] OOR_AT = BYTE_W'(FAT_WORDS * 4 - 1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]          fat_type_r;
  logic [SECTOR_W-1:0] das_r;
  logic [2:0]          shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat_type_r <= FAT_TYPE_12;
      das_r      <= '0;
      shift_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FAT_TYPE:      fat_type_r <= cfg_wdata[1:0];
        CFG_DATA_START:    das_r      <= cfg_wdata;
        CFG_CLUSTER_SHIFT: shift_r    <= cfg_wdata[2:0];
        default: ;  // no register at this index
      endcase
    end
  end

  // table format decode; code three behaves as FAT32
  logic is12, is16;
  always_comb begin
    is12 = 1'b0;
    is16 = 1'b0;
    unique case (fat_type_r) inside
      FAT_TYPE_12:               is12 = 1'b1;
      FAT_TYPE_16:               is16 = 1'b1;
      FAT_TYPE_32, FAT_TYPE_RSV: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Walk sequencer
  // ---------------------------------------------------------------------------
  walk_state_t state_r, state_nxt;

  logic in_fire, out_load;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // load path: write straight into the table at the accepting edge
  logic [XW-1:0] widx;
  logic          wr_en;
  assign widx  = XW'(in_word_index);
  assign wr_en = in_fire && (in_req_type == REQ_LOAD) && (widx < DEPTH_X);

  // query datapath registers
  logic [SECTOR_W-1:0] sector_r;
  logic [SECTOR_W-1:0] rel_r;     // sector - data area start
  logic                below_r;   // sector lies below the data area
  logic [SECTOR_W-1:0] clust_r;
  logic [BYTE_W-1:0]   boff_r;    // byte offset of the entry in the table
  logic [SECTOR_W-1:0] lm2_r;     // link - 2
  logic                link_ok_r;
  logic [SECTOR_W-1:0] res_r;
  logic                oor_r;

  logic [SECTOR_W:0]   diff;
  logic [SECTOR_W-1:0] inc;
  logic [SECTOR_W-1:0] smask;
  logic                last_sec;
  assign diff     = {1'b0, in_sector} - {1'b0, das_r};
  assign inc      = sector_r + SECTOR_W'(1);
  assign smask    = ~(~SECTOR_W'(0) << shift_r);
  assign last_sec = ((rel_r & smask) == smask);

  // entry address from the cluster number
  logic [BYTE_W-1:0] boff_calc;
  always_comb begin
    if (is12) begin
      boff_calc = {3'b000, clust_r} + {4'b0000, clust_r[SECTOR_W-1:1]};
    end else if (is16) begin
      boff_calc = {2'b00, clust_r, 1'b0};
    end else begin
      boff_calc = {1'b0, clust_r, 2'b00};
    end
  end

  // read ports; a straddling entry takes the next word on the second port
  logic          oor_calc;
  logic          rd_en;
  logic [AW-1:0] rd_addr0, rd_addr1;
  logic [WORD_W-1:0] rd_data0, rd_data1;
  assign oor_calc = (boff_r >= OOR_AT);
  assign rd_en    = (state_r == S_READ) && !oor_calc;
  assign rd_addr0 = boff_r[AW+1:2];
  assign rd_addr1 = rd_addr0 + AW'(boff_r[1:0] == 2'b11);

  fnsw_store #(
    .DEPTH (FAT_WORDS),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (widx[AW-1:0]),
    .wr_data  (in_word_data),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  // entry unpack from the returned words
  logic [1:0]  off0, off1;
  logic [7:0]  lo_byte, hi_byte;
  logic [15:0] v16;
  logic [31:0] ent;
  logic [31:0] limit;
  assign off0    = boff_r[1:0];
  assign off1    = boff_r[1:0] + 2'd1;
  assign lo_byte = 8'(rd_data0 >> {off0, 3'b000});
  assign hi_byte = 8'(rd_data1 >> {off1, 3'b000});
  assign v16     = {hi_byte, lo_byte};

  always_comb begin
    if (is12) begin
      ent   = clust_r[0] ? {20'd0, v16[15:4]} : {16'd0, v16 & FAT12_MASK};
      limit = FAT12_LIMIT;
    end else if (is16) begin
      ent   = {16'd0, v16};
      limit = FAT16_LIMIT;
    end else begin
      ent   = rd_data0 & FAT32_MASK;
      limit = FAT32_LIMIT;
    end
  end

  logic [SECTOR_W-1:0] mapped;
  assign mapped = (lm2_r << shift_r) + das_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire && in_req_type == REQ_QUERY) state_nxt = S_CLUS;
      S_CLUS: state_nxt = (!below_r && last_sec) ? S_BYTE : S_DONE;
      S_BYTE: state_nxt = S_READ;
      S_READ: state_nxt = oor_calc ? S_DONE : S_DATA;
      S_DATA: state_nxt = S_MAP;
      S_MAP:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        sector_r <= in_sector;
        rel_r    <= diff[SECTOR_W-1:0];
        below_r  <= diff[SECTOR_W];
        oor_r    <= 1'b0;
      end
      S_CLUS: begin
        if (below_r) begin
          res_r <= (inc == das_r) ? '0 : inc;
        end else begin
          res_r <= inc;
        end
        clust_r <= (rel_r >> shift_r) + SECTOR_W'(2);
      end
      S_BYTE: boff_r <= boff_calc;
      S_READ: begin
        oor_r <= oor_calc;
        res_r <= '0;
      end
      S_DATA: begin
        link_ok_r <= (ent >= 32'd2) && (ent < limit);
        lm2_r     <= ent - 32'd2;
      end
      S_MAP: res_r <= link_ok_r ? mapped : '0;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Output register: the result waits here while the front end goes idle
  // ---------------------------------------------------------------------------
  logic                out_valid_r, out_valid_nxt;
  logic [SECTOR_W-1:0] out_next_r;
  logic                out_oor_r;

  assign out_load      = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_next_r <= res_r;
      out_oor_r  <= oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_succ_sector  = out_next_r;
  assign out_end_of_chain = (out_next_r == '0);
  assign out_out_of_range = out_oor_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_AT(a_oor_ends, out_valid && out_out_of_range |-> out_end_of_chain, "oor without end")
  `ASSERT_NEXT(a_query_walks, in_fire && in_req_type == REQ_QUERY, state_r == S_CLUS, "query lost")
  `ASSERT_NEXT(a_read_to_data, rd_en, state_r == S_DATA, "read data not consumed")
  `ASSERT_AT(a_no_load_busy, wr_en |-> state_r == S_IDLE, "table write during walk")

endmodule

### design/fnsw_store.sv
module fnsw_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [fnsw_pkg::WORD_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr0,
  input  logic [AW-1:0]             rd_addr1,
  output logic [fnsw_pkg::WORD_W-1:0] rd_data0,
  output logic [fnsw_pkg::WORD_W-1:0] rd_data1
);
  import fnsw_pkg::*;

  // one write port, two registered read ports
  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule
